>>> sv/b64d_pkg.sv
package b64d_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned SextW  = 6;
  localparam int unsigned QDepth = 8;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = QPtrW + 1;
  // Most result entries one character can push.
  localparam int unsigned MaxPush = 3;

  localparam logic [CharW-1:0] ChUpA  = 8'h41;
  localparam logic [CharW-1:0] ChUpZ  = 8'h5A;
  localparam logic [CharW-1:0] ChLoA  = 8'h61;
  localparam logic [CharW-1:0] ChLoZ  = 8'h7A;
  localparam logic [CharW-1:0] ChDig0 = 8'h30;
  localparam logic [CharW-1:0] ChDig9 = 8'h39;
  localparam logic [CharW-1:0] ChPlus = 8'h2B;
  localparam logic [CharW-1:0] ChSlsh = 8'h2F;
  localparam logic [CharW-1:0] ChPad  = 8'h3D;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       bad;
  } res_t;

  typedef struct packed {
    logic             ok;
    logic [SextW-1:0] val;
  } sext_t;

  // Map one character of the standard alphabet; anything else reads as zero.
  function automatic sext_t map_char(input logic [CharW-1:0] c);
    sext_t r;
    logic [CharW-1:0] t;
    r.ok  = 1'b1;
    r.val = '0;
    t     = '0;
    if (c >= ChUpA && c <= ChUpZ) begin
      t = c - ChUpA;
    end else if (c >= ChLoA && c <= ChLoZ) begin
      t = c - ChLoA + 8'd26;
    end else if (c >= ChDig0 && c <= ChDig9) begin
      t = c - ChDig0 + 8'd52;
    end else if (c == ChPlus) begin
      t = 8'd62;
    end else if (c == ChSlsh) begin
      t = 8'd63;
    end else begin
      r.ok = 1'b0;
    end
    r.val = t[SextW-1:0];
    return r;
  endfunction

  // Pack four sextets into three bytes, first byte in the top bits.
  function automatic logic [23:0] make_bytes(input logic [SextW-1:0] s0,
                                             input logic [SextW-1:0] s1,
                                             input logic [SextW-1:0] s2,
                                             input logic [SextW-1:0] s3);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    b0 = {s0, s1[5:4]};
    b1 = {s1[3:0], s2[5:2]};
    b2 = {s2[1:0], s3};
    return {b0, b1, b2};
  endfunction

endpackage

>>> sv/base64_stream_decoder.sv
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+----------------------------------------
// in       | input     | in_valid_i / in_stall_o | char_code_i, end_of_string_i
// out      | output    | out_valid_o / out_stall_i | data_byte_o, byte_valid_o, last_o,
//          |           |                         | bad_char_o
//
// One character is taken per cycle while in_stall_o is low; it is decoded in the cycle
// it is taken and its zero to three results land in an eight-entry result queue,
// drained one per cycle while out_stall_i is low. in_stall_o rises only while the queue
// holds more than five results, so a stalled output side holds the input back after a
// few characters. The output rate is one result per cycle while out_stall_i is low.
// rst_ni clears the group, the flags and the queue at once; no pass is needed.
module base64_stream_decoder
  import b64d_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CharW-1:0] char_code_i,
  input  logic             end_of_string_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       data_byte_o,
  output logic             byte_valid_o,
  output logic             last_o,
  output logic             bad_char_o
);

  // Decoder state: collected sextets, their count, pad seen, bad char seen.
  logic [SextW-1:0] sext_q [3];
  logic [SextW-1:0] sext_d [3];
  logic [1:0]       gcnt_q, gcnt_d;
  logic             stop_q, stop_d;
  logic             bad_q, bad_d;

  // Result queue.
  res_t             queue_q [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  logic       in_acc, out_acc;
  logic       active, full;
  logic [2:0] gnew;
  sext_t      mapped;
  logic [23:0] bytes;
  logic [1:0] npush;
  res_t       push [MaxPush];

  // Leave room for a full group of three results on every accept.
  assign in_stall_o  = (cnt_q > QCntW'(QDepth - MaxPush));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_acc     = out_valid_o && !out_stall_i;

  always_comb begin
    logic [1:0] nb;
    mapped = map_char(char_code_i);
    active = !stop_q && (char_code_i != ChPad);
    full   = active && (gcnt_q == 2'd3);

    sext_d = sext_q;
    if (active && !full) begin
      sext_d[gcnt_q] = mapped.val;
    end
    gnew  = (active && !full) ? {1'b0, gcnt_q} + 3'd1 : (full ? 3'd0 : {1'b0, gcnt_q});
    bad_d = bad_q || (active && !mapped.ok);

    // A full group uses the stored three plus this one; a partial group pads zeros.
    if (full) begin
      bytes = make_bytes(sext_q[0], sext_q[1], sext_q[2], mapped.val);
    end else begin
      bytes = make_bytes(sext_d[0], sext_d[1], sext_d[2], '0);
    end

    if (full) begin
      nb = 2'd3;
    end else if (end_of_string_i && gnew >= 3'd2) begin
      nb = 2'(gnew - 3'd1);
    end else begin
      nb = 2'd0;
    end

    for (int k = 0; k < MaxPush; k++) begin
      push[k].data  = bytes[23 - 8*k -: 8];
      push[k].valid = 1'b1;
      push[k].last  = end_of_string_i && (nb == 2'(k + 1));
      push[k].bad   = end_of_string_i && (nb == 2'(k + 1)) && bad_d;
    end

    npush = nb;
    // End with no byte: emit one empty marker.
    if (end_of_string_i && nb == 2'd0) begin
      npush         = 2'd1;
      push[0].data  = '0;
      push[0].valid = 1'b0;
      push[0].last  = 1'b1;
      push[0].bad   = bad_d;
    end

    if (!in_acc) begin
      npush = 2'd0;
    end

    stop_d = stop_q || (char_code_i == ChPad);
    gcnt_d = gnew[1:0];
    // Return to the reset state after the end of a string.
    if (end_of_string_i) begin
      stop_d = 1'b0;
      gcnt_d = 2'd0;
      bad_d  = 1'b0;
      for (int k = 0; k < 3; k++) begin
        sext_d[k] = '0;
      end
    end

    wptr_d = wptr_q + QPtrW'(npush);
    rptr_d = rptr_q + QPtrW'(out_acc);
    cnt_d  = cnt_q + QCntW'(npush) - QCntW'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        sext_q[k] <= '0;
      end
      gcnt_q <= '0;
      stop_q <= 1'b0;
      bad_q  <= 1'b0;
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (in_acc) begin
        sext_q <= sext_d;
        gcnt_q <= gcnt_d;
        stop_q <= stop_d;
        bad_q  <= bad_d;
      end
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxPush; k++) begin
      if (2'(k) < npush) begin
        queue_q[wptr_q + QPtrW'(k)] <= push[k];
      end
    end
  end

  assign data_byte_o  = queue_q[rptr_q].data;
  assign byte_valid_o = queue_q[rptr_q].valid;
  assign last_o       = queue_q[rptr_q].last;
  assign bad_char_o   = queue_q[rptr_q].bad;

  // Queue never overfills.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  // The end of a string always produces at least one result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && end_of_string_i |=> out_valid_o)
    else $error("end of string produced no result");

  // The error flag travels only on the last result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_char_o |-> last_o)
    else $error("bad_char on a result that is not last");

  // An empty marker is always the last result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> last_o)
    else $error("empty result that is not last");

endmodule

>>> dv/tb.sv
module tb;
  import b64d_pkg::*;

  // Longest run of cycles in which neither side moves a request.
  localparam int IdleLimit = 1000;
  // Cycles to keep watching the output once nothing more is expected.
  localparam int DrainCycles = 20;

  typedef struct {
    logic [7:0] ch;
    logic       eos;
    bit         typed;  // use the typed result below instead of the decoder model
    res_t       want;
  } plan_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] char_code_i;
  logic       end_of_string_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] data_byte_o;
  logic       byte_valid_o;
  logic       last_o;
  logic       bad_char_o;

  base64_stream_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .char_code_i     (char_code_i),
    .end_of_string_i (end_of_string_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .data_byte_o     (data_byte_o),
    .byte_valid_o    (byte_valid_o),
    .last_o          (last_o),
    .bad_char_o      (bad_char_o)
  );

  // Decoder model state: sextets of the open group, how many are held, whether
  // padding has stopped the string, and whether a character outside the alphabet
  // has shown up in it.
  logic [5:0] grp_val [3];
  logic [1:0] grp_cnt;
  logic       pad_hit;
  logic       err_hit;

  res_t step_bytes[$];    // results of the character just taken
  res_t byte_expect_q[$]; // results still owed by the block, oldest first

  int errors;
  int chars_sent;
  int strings_sent;
  int results_seen;
  int idle_cycles;
  bit no_gaps;

  plan_row_t  plan [25];
  logic [7:0] text_q[$];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Six-bit value of one character, with bit 6 set when it is in the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    if (c >= ChUpA && c <= ChUpZ) return {1'b1, 6'(c - ChUpA)};
    if (c >= ChLoA && c <= ChLoZ) return {1'b1, 6'(c - ChLoA + 8'd26)};
    if (c >= ChDig0 && c <= ChDig9) return {1'b1, 6'(c - ChDig0 + 8'd52)};
    if (c == ChPlus) return {1'b1, 6'd62};
    if (c == ChSlsh) return {1'b1, 6'd63};
    return 7'd0;
  endfunction

  // Character that encodes a given sextet.
  function automatic logic [7:0] alpha_char(input int unsigned idx);
    if (idx < 26) return ChUpA + 8'(idx);
    if (idx < 52) return ChLoA + 8'(idx - 26);
    if (idx < 62) return ChDig0 + 8'(idx - 52);
    if (idx == 62) return ChPlus;
    return ChSlsh;
  endfunction

  // Advance the decoder model by one character and leave its results in step_bytes.
  function automatic void decode_char(input logic [7:0] c, input logic eos);
    logic [6:0] sx;
    logic [5:0] third;
    logic [7:0] b [3];
    int         n;
    res_t       r;
    n = 0;
    b[0] = '0;
    b[1] = '0;
    b[2] = '0;
    step_bytes.delete();
    if (!pad_hit) begin
      if (c == ChPad) begin
        pad_hit = 1'b1;
      end else begin
        sx = sextet_of(c);
        if (!sx[6]) err_hit = 1'b1;
        if (grp_cnt == 2'd3) begin
          b[0] = {grp_val[0], grp_val[1][5:4]};
          b[1] = {grp_val[1][3:0], grp_val[2][5:2]};
          b[2] = {grp_val[2][1:0], sx[5:0]};
          n = 3;
          grp_cnt = 2'd0;
        end else begin
          grp_val[grp_cnt] = sx[5:0];
          grp_cnt = grp_cnt + 2'd1;
        end
      end
    end
    // Flush a partial group at the end of the string; drop its unused low bits.
    if (eos && n == 0 && grp_cnt >= 2'd2) begin
      third = (grp_cnt == 2'd3) ? grp_val[2] : 6'd0;
      b[0] = {grp_val[0], grp_val[1][5:4]};
      b[1] = {grp_val[1][3:0], third[5:2]};
      n = int'(grp_cnt) - 1;
    end
    if (eos && n == 0) begin
      r = '{data: 8'h00, valid: 1'b0, last: 1'b1, bad: err_hit};
      step_bytes = {step_bytes, r};
    end else begin
      for (int i = 0; i < n; i++) begin
        r.data  = b[i];
        r.valid = 1'b1;
        r.last  = eos && (i == n - 1);
        r.bad   = eos && (i == n - 1) && err_hit;
        step_bytes = {step_bytes, r};
      end
    end
    if (eos) begin
      grp_val[0] = '0;
      grp_val[1] = '0;
      grp_val[2] = '0;
      grp_cnt = 2'd0;
      pad_hit = 1'b0;
      err_hit = 1'b0;
    end
  endfunction

  // Mostly back-to-back requests, now and then a short gap, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one character and hold it until the block takes it. Valid stays high
  // across back-to-back requests and only drops for a gap.
  task automatic send_char(input logic [7:0] c, input logic eos);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    char_code_i     = c;
    end_of_string_i = eos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chars_sent++;
    if (eos) strings_sent++;
  endtask

  // Send a whole character string and queue what the decoder model predicts.
  task automatic send_text();
    logic eos;
    for (int i = 0; i < text_q.size(); i++) begin
      eos = (i == text_q.size() - 1);
      send_char(text_q[i], eos);
      decode_char(text_q[i], eos);
      byte_expect_q = {byte_expect_q, step_bytes};
    end
  endtask

  // Drop valid and hold off until every owed result has come out.
  task automatic drain_pause();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (byte_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // Build one random string into text_q: mostly well-formed Base64 with random
  // content, some broken ones (stray bytes, padding in the middle), some noise.
  task automatic build_text();
    int mode;
    int len;
    int spot;
    mode = $urandom_range(0, 99);
    text_q.delete();
    if (mode < 65) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      repeat (len) text_q = {text_q, alpha_char($urandom_range(0, 63))};
      if ($urandom_range(0, 1) == 1) begin
        if (len % 4 == 2) begin
          text_q = {text_q, ChPad, ChPad};
        end else if (len % 4 == 3) begin
          text_q = {text_q, ChPad};
        end
        // Trailing junk, which must be ignored when it follows the padding.
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 4)) text_q = {text_q, 8'($urandom_range(0, 255))};
      end
    end else if (mode < 80) begin
      len = $urandom_range(2, 12);
      repeat (len) text_q = {text_q, alpha_char($urandom_range(0, 63))};
      spot = $urandom_range(0, len - 1);
      if ($urandom_range(0, 1) == 1) text_q[spot] = 8'($urandom_range(0, 255));
      else text_q[spot] = ChPad;
      if ($urandom_range(0, 2) == 0) text_q[$urandom_range(0, len - 1)] = 8'($urandom_range(128, 255));
    end else begin
      len = $urandom_range(1, 8);
      repeat (len) text_q = {text_q, 8'($urandom_range(0, 255))};
    end
  endtask

  // Output side: stall in bursts, mostly short, a few long, with stall-free runs.
  initial begin
    int left;
    bit stalling;
    out_stall_i = 1'b0;
    left = 0;
    stalling = 1'b0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        stalling = ($urandom_range(0, 99) < 45);
        if (!stalling) left = $urandom_range(1, 30);
        else if ($urandom_range(0, 9) == 0) left = $urandom_range(10, 40);
        else left = $urandom_range(1, 3);
      end
      out_stall_i = stalling;
      left--;
    end
  end

  // Compare every accepted result against the oldest one owed.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (byte_expect_q.size() == 0) begin
        $display("%0t: unexpected result data=%h valid=%b last=%b bad=%b", $time,
                 data_byte_o, byte_valid_o, last_o, bad_char_o);
        errors++;
      end else begin
        want = byte_expect_q[0];
        byte_expect_q.delete(0);
        if (data_byte_o !== want.data) begin
          $display("%0t: data_byte expected %h got %h", $time, want.data, data_byte_o);
          errors++;
        end
        if (byte_valid_o !== want.valid) begin
          $display("%0t: byte_valid expected %b got %b", $time, want.valid, byte_valid_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %b got %b", $time, want.last, last_o);
          errors++;
        end
        if (bad_char_o !== want.bad) begin
          $display("%0t: bad_char expected %b got %b", $time, want.bad, bad_char_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when neither side moves a request for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no progress for %0d cycles", $time, IdleLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] pick;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    char_code_i     = 8'h00;
    end_of_string_i = 1'b0;
    errors          = 0;
    chars_sent      = 0;
    strings_sent    = 0;
    results_seen    = 0;
    idle_cycles     = 0;
    no_gaps         = 1'b0;
    grp_val[0]      = '0;
    grp_val[1]      = '0;
    grp_val[2]      = '0;
    grp_cnt         = 2'd0;
    pad_hit         = 1'b0;
    err_hit         = 1'b0;

    // Directed strings. Typed rows each give exactly one result.
    plan = '{
      // padding alone right after reset: empty end marker
      '{ChPad,  1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
      // lone out-of-alphabet byte: empty end marker with the error flag
      '{8'h00,  1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
      // two top sextets: one all-ones byte
      '{ChSlsh, 1'b0, 1'b0, '0},
      '{ChSlsh, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},
      // all-zero group, then a single leftover sextet: empty end marker
      '{ChUpA,  1'b0, 1'b0, '0},
      '{ChUpA,  1'b0, 1'b0, '0},
      '{ChUpA,  1'b0, 1'b0, '0},
      '{ChUpA,  1'b0, 1'b0, '0},
      '{ChUpA,  1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
      // alphabet range edges, ending on a group of three sextets
      '{ChUpZ,  1'b0, 1'b0, '0},
      '{ChLoA,  1'b0, 1'b0, '0},
      '{ChLoZ,  1'b0, 1'b0, '0},
      '{ChDig0, 1'b0, 1'b0, '0},
      '{ChDig9, 1'b0, 1'b0, '0},
      '{ChPlus, 1'b0, 1'b0, '0},
      '{ChSlsh, 1'b1, 1'b0, '0},
      // bad byte inside a group, padding, then ignored junk carrying the end mark
      '{8'h51,  1'b0, 1'b0, '0},
      '{8'h52,  1'b0, 1'b0, '0},
      '{8'hFF,  1'b0, 1'b0, '0},
      '{ChPad,  1'b0, 1'b0, '0},
      '{8'h80,  1'b0, 1'b0, '0},
      '{ChUpA,  1'b1, 1'b0, '0},
      // padding as the last character, nonzero leftover bits
      '{8'h51,  1'b0, 1'b0, '0},
      '{8'h52,  1'b0, 1'b0, '0},
      '{ChPad,  1'b1, 1'b0, '0}
    };

    // Hold reset, then release it away from the clock edge.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      send_char(plan[i].ch, plan[i].eos);
      decode_char(plan[i].ch, plan[i].eos);
      if (plan[i].typed) byte_expect_q = {byte_expect_q, plan[i].want};
      else byte_expect_q = {byte_expect_q, step_bytes};
    end

    // Let the directed results drain completely before the random strings.
    drain_pause();

    while (chars_sent < 260) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      build_text();
      send_text();
      // Once in the middle, stop and wait for every owed result.
      if (strings_sent == 30) drain_pause();
    end

    // Finish with a short string of a random byte and its complement.
    pick = 8'($urandom_range(0, 255));
    text_q.delete();
    text_q = {text_q, pick, ~pick};
    send_text();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (byte_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Decoded %0d characters in %0d strings; %0d results checked, %0d mismatches.",
             chars_sent, strings_sent, results_seen, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
sv/b64d_pkg.sv
sv/base64_stream_decoder.sv
dv/tb.sv
